// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent, written as a full property
`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// expression never holds
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// ===== hdl/pcxrle_pkg.sv =====
// ----------------------------------------------------------------------------
// PCX RLE palette decoder package
// Shared constants, command codes, queue item and pixel types.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam int MAX_DIM  = 1024;
    localparam int PAL_SIZE = 256;
    localparam int POS_W    = 10;
    localparam int IDX_W    = $clog2(PAL_SIZE);
    localparam int CNT_W    = 6;
    localparam int COL_W    = 8;
    localparam int RGB_W    = 3 * COL_W;
    localparam int CMD_W    = 2;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [7:0] RUN_MASK = 8'h3F;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_PAL   = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_LAST_COLUMN = 1'b0,
        REG_LAST_ROW    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PAL   = 2'd1,
        OP_EMIT  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] count;
        logic [RGB_W-1:0] rgb;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             run_last;
        logic             image_done;
    } pix_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    function automatic logic [POS_W-1:0] clamp_dim(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] r;
        r = v;
        if (int'(v) > MAX_DIM - 1) begin
            r = POS_W'(MAX_DIM - 1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/pcxrle_front.sv =====
// ----------------------------------------------------------------------------
// PCX RLE front end
// Accepts input items, resolves run prefixes and queues work for the back end.
// ----------------------------------------------------------------------------
module pcxrle_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pcxrle_pkg::CMD_W-1:0] s_cmd,
    input  logic [7:0]                   s_code_byte,
    input  logic [pcxrle_pkg::IDX_W-1:0] s_pal_index,
    input  logic [pcxrle_pkg::COL_W-1:0] s_pal_red,
    input  logic [pcxrle_pkg::COL_W-1:0] s_pal_green,
    input  logic [pcxrle_pkg::COL_W-1:0] s_pal_blue,
    input  pcxrle_pkg::q_status_t        q_status,
    output logic                         q_wr_en,
    output pcxrle_pkg::op_t              q_wr_data
);
    import pcxrle_pkg::*;

    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_comb begin
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        q_wr_en         = 1'b0;
        q_wr_data.kind  = OP_EMIT;
        q_wr_data.index = s_code_byte[IDX_W-1:0];
        q_wr_data.count = CNT_W'(1);
        q_wr_data.rgb   = {s_pal_red, s_pal_green, s_pal_blue};
        if (accept) begin
            case (s_cmd)
                CMD_START: begin
                    pend_next      = 1'b0;
                    cnt_next       = '0;
                    q_wr_en        = 1'b1;
                    q_wr_data.kind = OP_START;
                end
                CMD_PAL: begin
                    q_wr_en         = 1'b1;
                    q_wr_data.kind  = OP_PAL;
                    q_wr_data.index = s_pal_index;
                end
                CMD_DATA: begin
                    if (pend_reg) begin
                        // resolve the run; drop zero-length runs here
                        pend_next       = 1'b0;
                        cnt_next        = '0;
                        q_wr_en         = (cnt_reg != '0);
                        q_wr_data.count = cnt_reg;
                    end else if ((s_code_byte & RUN_MARK) == RUN_MARK) begin
                        pend_next = 1'b1;
                        cnt_next  = CNT_W'(s_code_byte & RUN_MASK);
                    end else begin
                        q_wr_en = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/pcxrle_queue.sv =====
// ----------------------------------------------------------------------------
// PCX RLE work queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module pcxrle_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  pcxrle_pkg::op_t       wr_data,
    input  logic                  rd_en,
    output pcxrle_pkg::op_t       rd_data,
    output pcxrle_pkg::q_status_t status
);
    import pcxrle_pkg::*;

    op_t             slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   fill_reg;
    logic            do_wr, do_rd;

    assign status.full  = (fill_reg == (Q_AW + 1)'(Q_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/pcxrle_back.sv =====
// ----------------------------------------------------------------------------
// PCX RLE back end
// Holds the palette and raster position, expands runs into pixel items.
// ----------------------------------------------------------------------------
module pcxrle_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pcxrle_pkg::q_status_t        q_status,
    input  pcxrle_pkg::op_t              q_rd_data,
    output logic                         q_rd_en,
    input  logic [pcxrle_pkg::POS_W-1:0] lc,
    input  logic [pcxrle_pkg::POS_W-1:0] lr,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pcxrle_pkg::pix_t             m_pix
);
    import pcxrle_pkg::*;

    logic [RGB_W-1:0] pal_mem [PAL_SIZE];
    logic [RGB_W-1:0] rd_data_reg;
    logic             mem_we, mem_re;

    back_state_t      state_reg, state_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic             fin_reg, fin_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             m_valid_reg, m_valid_next;
    pix_t             pix_reg, pix_next;

    logic out_free, row_end, last, run_end;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pal_mem[q_rd_data.index] <= q_rd_data.rgb;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= pal_mem[q_rd_data.index];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            fin_reg     <= 1'b0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            fin_reg     <= fin_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign row_end  = (col_reg >= lc);
    assign last     = row_end && (row_reg >= lr);
    assign run_end  = row_end || (remain_reg == CNT_W'(1));

    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        fin_next     = fin_reg;
        remain_next  = remain_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pix_next     = pix_reg;
        q_rd_en      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    q_rd_en = 1'b1;
                    case (q_rd_data.kind)
                        OP_START: begin
                            col_next = '0;
                            row_next = '0;
                            fin_next = 1'b0;
                        end
                        OP_PAL: begin
                            mem_we = 1'b1;
                        end
                        OP_EMIT: begin
                            // drop pixels once the image is complete
                            if (!fin_reg) begin
                                mem_re      = 1'b1;
                                remain_next = q_rd_data.count;
                                state_next  = BK_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_RUN: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    pix_next.red        = rd_data_reg[RGB_W-1 -: COL_W];
                    pix_next.green      = rd_data_reg[COL_W +: COL_W];
                    pix_next.blue       = rd_data_reg[COL_W-1:0];
                    pix_next.column     = col_reg;
                    pix_next.row        = row_reg;
                    pix_next.run_last   = run_end;
                    pix_next.image_done = last;
                    remain_next         = remain_reg - 1'b1;
                    if (row_end) begin
                        col_next = '0;
                        if (last) begin
                            fin_next = 1'b1;
                        end else begin
                            row_next = row_reg + 1'b1;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                    if (run_end) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_pix   = pix_reg;

endmodule

// ===== hdl/pcx_rle_palette_decoder.sv =====
// ----------------------------------------------------------------------------
// PCX RLE palette decoder
// Decodes an 8-bit PCX run-length stream into palette RGB pixels.
// ----------------------------------------------------------------------------
// Channel  Ports                                          Direction
// input    s_valid s_ready s_cmd s_code_byte s_pal_*      in
// result   m_valid m_ready m_red m_green m_blue m_column  out
//          m_row m_run_last m_image_done
// config   cfg_valid cfg_ready cfg_index cfg_data         in
//
// Front end takes one item per cycle while the 4-entry queue has room.
// Back end: start and palette items are applied straight from the queue; a pixel byte or a run
// first reads the palette, then emits one pixel per cycle while m_ready does not stall it.
// Synchronous active-low reset clears position, queue and run state;
// the palette holds its contents. A stalled m_ready holds the run in place.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcx_rle_palette_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pcxrle_pkg::CMD_W-1:0] s_cmd,
    input  logic [7:0]                   s_code_byte,
    input  logic [pcxrle_pkg::IDX_W-1:0] s_pal_index,
    input  logic [pcxrle_pkg::COL_W-1:0] s_pal_red,
    input  logic [pcxrle_pkg::COL_W-1:0] s_pal_green,
    input  logic [pcxrle_pkg::COL_W-1:0] s_pal_blue,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pcxrle_pkg::COL_W-1:0] m_red,
    output logic [pcxrle_pkg::COL_W-1:0] m_green,
    output logic [pcxrle_pkg::COL_W-1:0] m_blue,
    output logic [pcxrle_pkg::POS_W-1:0] m_column,
    output logic [pcxrle_pkg::POS_W-1:0] m_row,
    output logic                         m_run_last,
    output logic                         m_image_done,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [pcxrle_pkg::POS_W-1:0] cfg_data
);
    import pcxrle_pkg::*;

    logic [POS_W-1:0] last_column_reg, last_row_reg;
    logic [POS_W-1:0] lc, lr;
    q_status_t        q_status;
    logic             q_wr_en, q_rd_en;
    op_t              q_wr_data, q_rd_data;
    pix_t             pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_column_reg <= '0;
            last_row_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LAST_COLUMN: last_column_reg <= cfg_data;
                REG_LAST_ROW:    last_row_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign lc = clamp_dim(last_column_reg);
    assign lr = clamp_dim(last_row_reg);

    pcxrle_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_code_byte (s_code_byte),
        .s_pal_index (s_pal_index),
        .s_pal_red   (s_pal_red),
        .s_pal_green (s_pal_green),
        .s_pal_blue  (s_pal_blue),
        .q_status    (q_status),
        .q_wr_en     (q_wr_en),
        .q_wr_data   (q_wr_data)
    );

    pcxrle_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    pcxrle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_rd_data (q_rd_data),
        .q_rd_en   (q_rd_en),
        .lc        (lc),
        .lr        (lr),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pix     (pix)
    );

    assign m_red        = pix.red;
    assign m_green      = pix.green;
    assign m_blue       = pix.blue;
    assign m_column     = pix.column;
    assign m_row        = pix.row;
    assign m_run_last   = pix.run_last;
    assign m_image_done = pix.image_done;

    `ASSERT_NEVER(a_queue_overflow, q_status.full && q_wr_en, "queue write while full")
    `ASSERT_IMPL(a_done_ends_run, m_valid && m_image_done |-> m_run_last, "image end mid-run")
    `ASSERT_IMPL(a_done_at_corner, m_valid && m_image_done |-> (m_column >= lc) && (m_row >= lr), "image end off corner")

endmodule
